// ----- design/mbrf_pkg.sv -----
`default_nettype none

package mbrf_pkg;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [7:0]  FUNC_INPUT    = 8'h04;
	localparam logic [7:0]  FUNC_HOLDING  = 8'h03;
	localparam logic [7:0]  COUNT_INPUT   = 8'h02;
	localparam logic [7:0]  COUNT_HOLDING = 8'h01;
	localparam logic [7:0]  COUNT_HIGH    = 8'h00;
	localparam logic [7:0]  SLAVE_ID_INIT = 8'h01;
	localparam int          FRAME_LEN     = 8;
	localparam int          POS_W         = $clog2(FRAME_LEN);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

	// Request kind codes
	localparam logic KIND_INPUT   = 1'b0;
	localparam logic KIND_HOLDING = 1'b1;

	// Request fields carried down the CRC pipeline
	typedef struct packed {
		logic [7:0]  slave_id;
		logic        kind;
		logic [15:0] start_address;
	} mbrf_req_t;

	// Header plus finished CRC, handed to the serializer
	typedef struct packed {
		mbrf_req_t   req;
		logic [15:0] crc;
	} mbrf_frame_t;

	// Fold one byte into the CRC, LSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] func_code(input logic kind);
		return (kind == KIND_HOLDING) ? FUNC_HOLDING : FUNC_INPUT;
	endfunction

	function automatic logic [7:0] count_low(input logic kind);
		return (kind == KIND_HOLDING) ? COUNT_HOLDING : COUNT_INPUT;
	endfunction

endpackage

`default_nettype wire

// ----- design/modbus_read_request_framer.sv -----
// Modbus RTU read request framer. Each accepted request (kind, start_address) becomes one
// eight-byte frame on the output: slave id, function code (0x04 for kind 0, 0x03 for kind 1),
// address high and low, register count high and low (2 for kind 0, 1 for kind 1), then the
// CRC-16/MODBUS low and high bytes; last_byte marks the CRC high byte. The CRC is computed in
// a three-stage pipeline, two header bytes per stage, and the finished frame is shifted out
// one byte per cycle while out_stall is low, so the byte serializer sets the sustained request
// rate. A request passes through the three CRC stages and is then loaded into the serializer
// before its first byte is offered. Up to three further requests wait in the CRC stages while
// a frame streams out. slave_id resets to 1 and should be written only while no frame is in
// flight.
`default_nettype none

module modbus_read_request_framer import mbrf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [15:0] start_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);

	logic [7:0]  slave_id_q;
	mbrf_req_t   in_req;
	logic        frm_valid;
	logic        frm_ready;
	mbrf_frame_t frm;

	// Hold the slave address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= SLAVE_ID_INIT;
		end else if (cfg_wr_en) begin
			slave_id_q <= cfg_wr_data;
		end
	end

	assign in_req.slave_id      = slave_id_q;
	assign in_req.kind          = kind;
	assign in_req.start_address = start_address;

	mbrf_crc_pipe u_crc_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	mbrf_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.frm_valid  (frm_valid),
		.frm_ready  (frm_ready),
		.frm        (frm),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire

// ----- design/mbrf_crc_pipe.sv -----
`default_nettype none

module mbrf_crc_pipe import mbrf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire mbrf_req_t   in_req,
	output logic             frm_valid,
	input  wire logic        frm_ready,
	output mbrf_frame_t      frm
);

	logic        v_s1, v_s2, v_s3;
	mbrf_req_t   req_s1, req_s2, req_s3;
	logic [15:0] crc_s1, crc_s2, crc_s3;
	logic        ready_s1, ready_s2, ready_s3;

	// Advance a stage when it is empty or its contents move on
	assign ready_s3 = !v_s3 || frm_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: slave id and function code
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			req_s1 <= in_req;
			crc_s1 <= crc_fold(crc_fold(CRC_INIT, in_req.slave_id), func_code(in_req.kind));
		end
	end

	// Stage 2: start address, high byte then low byte
	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			req_s2 <= req_s1;
			crc_s2 <= crc_fold(crc_fold(crc_s1, req_s1.start_address[15:8]),
				req_s1.start_address[7:0]);
		end
	end

	// Stage 3: register count, high byte then low byte
	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			req_s3 <= req_s2;
			crc_s3 <= crc_fold(crc_fold(crc_s2, COUNT_HIGH), count_low(req_s2.kind));
		end
	end

	assign frm_valid = v_s3;
	assign frm.req   = req_s3;
	assign frm.crc   = crc_s3;

endmodule

`default_nettype wire

// ----- design/mbrf_serializer.sv -----
`default_nettype none

module mbrf_serializer import mbrf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         frm_valid,
	output logic              frm_ready,
	input  wire mbrf_frame_t  frm,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        frame_byte,
	output logic              last_byte
);

	logic                  busy_q;
	logic [POS_W-1:0]      pos_q;
	logic [8*FRAME_LEN-1:0] shift_q;
	logic                  at_last;
	logic                  take;

	assign at_last   = (pos_q == LAST_POS);
	// Load the next frame when idle or as the final byte leaves
	assign frm_ready = !busy_q || (at_last && !out_stall);
	assign take      = frm_valid && frm_ready;

	// Byte counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q && !out_stall) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end
			pos_q <= pos_q + POS_W'(1);
		end
	end

	// Frame bytes, first byte in the low lane; shift down as bytes leave
	always_ff @(posedge clk) begin
		if (take) begin
			shift_q <= {frm.crc[15:8], frm.crc[7:0], count_low(frm.req.kind), COUNT_HIGH,
				frm.req.start_address[7:0], frm.req.start_address[15:8],
				func_code(frm.req.kind), frm.req.slave_id};
		end else if (busy_q && !out_stall) begin
			shift_q <= {8'h00, shift_q[8*FRAME_LEN-1:8]};
		end
	end

	assign out_valid  = busy_q;
	assign frame_byte = shift_q[7:0];
	assign last_byte  = at_last;

endmodule

`default_nettype wire

// ----- design/mbrf_checker.sv -----
`default_nettype none

module mbrf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] frame_byte,
	input wire logic       last_byte
);

	// A stalled request stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped under stall");

	// A stalled request keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(frame_byte) && $stable(last_byte))
		else $error("output payload changed under stall");

	// A frame never breaks off before its last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> out_valid)
		else $error("frame cut short");

	// A valid last byte is never directly followed by another valid last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_byte |=> !(out_valid && last_byte))
		else $error("frame shorter than eight bytes");

endmodule

bind modbus_read_request_framer mbrf_checker u_mbrf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);

`default_nettype wire
